// File: hw/rtl/brainfuck_execution_core_defines.svh
// Assertion macros used by the execution core back end.
`ifndef BRAINFUCK_EXECUTION_CORE_DEFINES_SVH
`define BRAINFUCK_EXECUTION_CORE_DEFINES_SVH

// Condition holds at every rising clock edge outside reset.
`define BFC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BFC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define BFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/bfc_pkg.sv
// Shared constants, opcode and word types of the execution core.
package bfc_pkg;

   localparam int TAPE_CELLS  = 4096;
   localparam int STACK_DEPTH = 256;
   localparam int QUEUE_DEPTH = 2;

   localparam int CHAR_W = 8;
   localparam int POS_W  = 16;
   localparam int BYTE_W = 8;
   localparam int ERR_W  = 2;
   localparam int SKIP_W = 16;

   // Program characters that act
   localparam logic [CHAR_W-1:0] CH_RIGHT = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_LEFT  = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_INC   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_DEC   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_OUT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_IN    = 8'h2C;
   localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h5D;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_RIGHT,
      OP_LEFT,
      OP_INC,
      OP_DEC,
      OP_OUT,
      OP_IN,
      OP_OPEN,
      OP_CLOSE
   } op_type;

   // Decoded word passed from front to back
   typedef struct packed {
      op_type              op;
      logic [POS_W-1:0]    pos;
      logic [BYTE_W-1:0]   in_byte;
      logic                in_eof;
   } item_type;

   // Result word
   typedef struct packed {
      logic                out_valid;
      logic [BYTE_W-1:0]   out_byte;
      logic                redirect;
      logic [POS_W-1:0]    redirect_pos;
      logic [ERR_W-1:0]    error_code;
      logic                skipping;
   } result_type;

endpackage

// File: hw/rtl/bfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read (old data on a same-address collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bfc_front.sv
// Front end: accepts request words and decodes the program character.
module bfc_front (
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bfc_pkg::CHAR_W-1:0]        req_action,
   input  logic [bfc_pkg::POS_W-1:0]         req_prog_pos,
   input  logic [bfc_pkg::BYTE_W-1:0]        req_in_byte,
   input  logic                              req_in_eof,
   input  logic                              queue_full,
   input  logic                              tape_clearing,
   output logic                              push_valid,
   output bfc_pkg::item_type                 push_item
);

   bfc_pkg::op_type op;

   // Classify the character
   always_comb begin
      case (req_action)
         bfc_pkg::CH_RIGHT: op = bfc_pkg::OP_RIGHT;
         bfc_pkg::CH_LEFT:  op = bfc_pkg::OP_LEFT;
         bfc_pkg::CH_INC:   op = bfc_pkg::OP_INC;
         bfc_pkg::CH_DEC:   op = bfc_pkg::OP_DEC;
         bfc_pkg::CH_OUT:   op = bfc_pkg::OP_OUT;
         bfc_pkg::CH_IN:    op = bfc_pkg::OP_IN;
         bfc_pkg::CH_OPEN:  op = bfc_pkg::OP_OPEN;
         bfc_pkg::CH_CLOSE: op = bfc_pkg::OP_CLOSE;
         default:           op = bfc_pkg::OP_NOP;
      endcase
   end

   // Hold requests while the queue is full or the tape is being cleared
   assign req_stall  = queue_full | tape_clearing;
   assign push_valid = req_valid & ~req_stall;

   always_comb begin
      push_item.op      = op;
      push_item.pos     = req_prog_pos;
      push_item.in_byte = req_in_byte;
      push_item.in_eof  = req_in_eof;
   end

endmodule

// File: hw/rtl/bfc_queue.sv
// Short queue of decoded words between front end and execution back end.
module bfc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  bfc_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output bfc_pkg::item_type head_item
);

   localparam int QD  = bfc_pkg::QUEUE_DEPTH;
   localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
   localparam int QCW = $clog2(QD + 1);
   localparam logic [QPW-1:0] PTR_LAST = QPW'(QD - 1);
   localparam logic [QCW-1:0] COUNT_FULL = QCW'(QD);

   bfc_pkg::item_type entry_ff [QD];
   logic [QPW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]    count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + QPW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + QPW'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + QCW'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store incoming words
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full       = (count_ff == COUNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

endmodule

// File: hw/rtl/bfc_back.sv
// Execution back end: tape, loop stack, skip tracking and result register.
`include "brainfuck_execution_core_defines.svh"

module bfc_back #(
   parameter int TAPE_CELLS  = bfc_pkg::TAPE_CELLS,
   parameter int STACK_DEPTH = bfc_pkg::STACK_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  bfc_pkg::item_type   q_item,
   output logic                q_pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bfc_pkg::result_type rsp_data
);

   localparam int TAW = $clog2(TAPE_CELLS);
   localparam int SIW = $clog2(STACK_DEPTH);
   localparam int SCW = $clog2(STACK_DEPTH + 1);
   localparam int BW  = bfc_pkg::BYTE_W;
   localparam int PW  = bfc_pkg::POS_W;
   localparam int DW  = bfc_pkg::SKIP_W;
   localparam logic [TAW-1:0] PTR_LAST  = TAW'(TAPE_CELLS - 1);
   localparam logic [SCW-1:0] STK_FULL  = SCW'(STACK_DEPTH);

   // State
   logic             clearing_ff;
   logic [TAW-1:0]   clear_addr_ff;
   logic [TAW-1:0]   ptr_ff, ptr_in;
   logic [SCW-1:0]   cnt_ff, cnt_in;
   logic             skip_ff, skip_in;
   logic [DW-1:0]    depth_ff, depth_in;

   // Write forwarding around the registered RAM reads
   logic             tfwd_valid_ff;
   logic [TAW-1:0]   tfwd_addr_ff;
   logic [BW-1:0]    tfwd_data_ff;
   logic             sfwd_valid_ff;
   logic [SIW-1:0]   sfwd_addr_ff;
   logic [PW-1:0]    sfwd_data_ff;

   logic                rsp_valid_ff;
   bfc_pkg::result_type rsp_ff, res;

   // Memory ports
   logic             tape_we;
   logic [TAW-1:0]   tape_waddr, tape_raddr;
   logic [BW-1:0]    tape_wdata, tape_rdata;
   logic             stk_we;
   logic [SIW-1:0]   stk_waddr, stk_raddr;
   logic [PW-1:0]    stk_wdata, stk_rdata;

   logic             fire;
   logic [BW-1:0]    cur_cell, cell_new;
   logic             cell_wr;
   logic [SCW-1:0]   cnt_dec, cnt_in_dec;
   logic [SIW-1:0]   top_idx;
   logic [PW-1:0]    top;

   bfc_ram #(.WIDTH(BW), .DEPTH(TAPE_CELLS)) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata),
      .rd_addr (tape_raddr),
      .rd_data (tape_rdata)
   );

   bfc_ram #(.WIDTH(PW), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // Execute the head word when the result register can take it and the tape is not being cleared
   assign fire  = q_valid & ~clearing_ff & (~rsp_valid_ff | ~rsp_stall);
   assign q_pop = fire;

   // Current cell and top of stack, corrected by the last write
   always_comb begin
      cur_cell = (tfwd_valid_ff && tfwd_addr_ff == ptr_ff) ? tfwd_data_ff : tape_rdata;
      cnt_dec  = cnt_ff - SCW'(1);
      top_idx  = cnt_dec[SIW-1:0];
      top      = (sfwd_valid_ff && sfwd_addr_ff == top_idx) ? sfwd_data_ff : stk_rdata;
   end

   // Next state and result
   always_comb begin
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      skip_in  = skip_ff;
      depth_in = depth_ff;
      cell_wr  = 1'b0;
      cell_new = cur_cell;
      stk_we   = 1'b0;
      res      = '0;
      if (fire) begin
         if (skip_ff) begin
            if (q_item.op == bfc_pkg::OP_OPEN) begin
               if (depth_ff != '1) begin
                  depth_in = depth_ff + DW'(1);
               end
            end else if (q_item.op == bfc_pkg::OP_CLOSE) begin
               if (depth_ff == '0) begin
                  skip_in = 1'b0;
               end else begin
                  depth_in = depth_ff - DW'(1);
               end
            end
         end else begin
            case (q_item.op)
               bfc_pkg::OP_RIGHT: begin
                  ptr_in = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + TAW'(1);
               end
               bfc_pkg::OP_LEFT: begin
                  ptr_in = (ptr_ff == '0) ? PTR_LAST : ptr_ff - TAW'(1);
               end
               bfc_pkg::OP_INC: begin
                  cell_wr  = 1'b1;
                  cell_new = cur_cell + BW'(1);
               end
               bfc_pkg::OP_DEC: begin
                  cell_wr  = 1'b1;
                  cell_new = cur_cell - BW'(1);
               end
               bfc_pkg::OP_OUT: begin
                  res.out_valid = 1'b1;
                  res.out_byte  = cur_cell;
               end
               bfc_pkg::OP_IN: begin
                  if (!q_item.in_eof) begin
                     cell_wr  = 1'b1;
                     cell_new = q_item.in_byte;
                  end
               end
               bfc_pkg::OP_OPEN: begin
                  if (cur_cell == '0) begin
                     skip_in  = 1'b1;
                     depth_in = '0;
                  end else if (cnt_ff == STK_FULL) begin
                     res.error_code = bfc_pkg::ERR_OVERFLOW;
                  end else begin
                     stk_we = 1'b1;
                     cnt_in = cnt_ff + SCW'(1);
                  end
               end
               bfc_pkg::OP_CLOSE: begin
                  if (cnt_ff == '0) begin
                     res.error_code = bfc_pkg::ERR_UNDERFLOW;
                  end else begin
                     cnt_in           = cnt_dec;
                     res.redirect     = 1'b1;
                     res.redirect_pos = top;
                  end
               end
               default: begin
               end
            endcase
         end
         res.skipping = skip_in;
      end
   end

   // Memory addressing: read at the pointer and stack top of the next cycle
   always_comb begin
      tape_we    = clearing_ff | cell_wr;
      tape_waddr = clearing_ff ? clear_addr_ff : ptr_ff;
      tape_wdata = clearing_ff ? '0 : cell_new;
      tape_raddr = ptr_in;
      stk_waddr  = cnt_ff[SIW-1:0];
      stk_wdata  = q_item.pos;
      cnt_in_dec = cnt_in - SCW'(1);
      stk_raddr  = cnt_in_dec[SIW-1:0];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         ptr_ff        <= '0;
         cnt_ff        <= '0;
         skip_ff       <= 1'b0;
         depth_ff      <= '0;
         tfwd_valid_ff <= 1'b0;
         sfwd_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clear_addr_ff <= clear_addr_ff + TAW'(1);
            if (clear_addr_ff == PTR_LAST) begin
               clearing_ff <= 1'b0;
            end
         end
         ptr_ff        <= ptr_in;
         cnt_ff        <= cnt_in;
         skip_ff       <= skip_in;
         depth_ff      <= depth_in;
         tfwd_valid_ff <= tfwd_valid_ff | tape_we;
         sfwd_valid_ff <= sfwd_valid_ff | stk_we;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: forwarding copies and result word
   always_ff @(posedge clock) begin
      if (tape_we) begin
         tfwd_addr_ff <= tape_waddr;
         tfwd_data_ff <= tape_wdata;
      end
      if (stk_we) begin
         sfwd_addr_ff <= stk_waddr;
         sfwd_data_ff <= stk_wdata;
      end
      if (fire) begin
         rsp_ff <= res;
      end
   end

   assign clearing  = clearing_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `BFC_ASSERT_NEXT(a_push_counts, clock, reset, stk_we, cnt_ff == $past(cnt_ff) + SCW'(1), "push did not raise the stack count")
   `BFC_ASSERT_ALWAYS(a_count_bound, clock, reset, cnt_ff <= STK_FULL, "stack count beyond depth")
   `BFC_ASSERT_IMPLIES(a_no_exec_clear, clock, reset, clearing_ff, !q_pop && !cell_wr, "word executed during tape clear")
   `BFC_ASSERT_IMPLIES(a_skip_quiet, clock, reset, rsp_valid_ff && rsp_ff.skipping, !rsp_ff.out_valid && !rsp_ff.redirect && rsp_ff.error_code == bfc_pkg::ERR_OK, "activity reported while skipping")

endmodule

// File: hw/rtl/brainfuck_execution_core.sv
// Top level of the execution core: front end, word queue and back end.
//
//   channel | ports        | direction | word
//   --------+--------------+-----------+-------------------------------------------
//   request | req_valid/stall  | in    | action, prog_pos, in_byte, in_eof
//   result  | rsp_valid/stall  | out   | out_valid, out_byte, redirect,
//           |                  |       | redirect_pos, error_code, skipping
//
// One word is executed per cycle while one is queued, the tape is not being cleared
// and the result is not stalled; each request's result passes a queue slot, then the
// result register. The tape read-modify-write of consecutive words is closed by a
// one-word write forward around the registered tape RAM read.
// After reset the tape is cleared one cell a cycle, with req_stall high throughout.
// A stalled result holds the back end; the two-word queue keeps accepting until full.
module brainfuck_execution_core #(
   parameter int TAPE_CELLS  = bfc_pkg::TAPE_CELLS,
   parameter int STACK_DEPTH = bfc_pkg::STACK_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bfc_pkg::CHAR_W-1:0]    req_action,
   input  logic [bfc_pkg::POS_W-1:0]     req_prog_pos,
   input  logic [bfc_pkg::BYTE_W-1:0]    req_in_byte,
   input  logic                          req_in_eof,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_out_valid,
   output logic [bfc_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_redirect,
   output logic [bfc_pkg::POS_W-1:0]     rsp_redirect_pos,
   output logic [bfc_pkg::ERR_W-1:0]     rsp_error_code,
   output logic                          rsp_skipping
);

   logic                queue_full;
   logic                tape_clearing;
   logic                push_valid;
   bfc_pkg::item_type   push_item;
   logic                head_valid;
   bfc_pkg::item_type   head_item;
   logic                pop;
   bfc_pkg::result_type rsp_data;

   bfc_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_prog_pos  (req_prog_pos),
      .req_in_byte   (req_in_byte),
      .req_in_eof    (req_in_eof),
      .queue_full    (queue_full),
      .tape_clearing (tape_clearing),
      .push_valid    (push_valid),
      .push_item     (push_item)
   );

   bfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   bfc_back #(
      .TAPE_CELLS  (TAPE_CELLS),
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (head_valid),
      .q_item    (head_item),
      .q_pop     (pop),
      .clearing  (tape_clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Unpack the result word
   assign rsp_out_valid    = rsp_data.out_valid;
   assign rsp_out_byte     = rsp_data.out_byte;
   assign rsp_redirect     = rsp_data.redirect;
   assign rsp_redirect_pos = rsp_data.redirect_pos;
   assign rsp_error_code   = rsp_data.error_code;
   assign rsp_skipping     = rsp_data.skipping;

endmodule
